FILE: rtl/core/akd_pkg.sv
// Shared key codes, result beat type and byte decode functions for the key sequence decoder.
package akd_pkg;

  // Key event codes carried in the result beat
  typedef enum logic [3:0] {
    KEY_CHAR      = 4'd0,
    KEY_ENTER     = 4'd1,
    KEY_BACKSPACE = 4'd2,
    KEY_TAB       = 4'd3,
    KEY_CTRL_C    = 4'd4,
    KEY_ESCAPE    = 4'd5,
    KEY_UP        = 4'd6,
    KEY_DOWN      = 4'd7,
    KEY_RIGHT     = 4'd8,
    KEY_LEFT      = 4'd9,
    KEY_HOME      = 4'd10,
    KEY_END       = 4'd11,
    KEY_DELETE    = 4'd12
  } key_t;

  // Input kind carried in tuser
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // Bytes with a meaning of their own
  localparam logic [7:0] BYTE_CTRL_C = 8'd3;
  localparam logic [7:0] BYTE_BS     = 8'd8;
  localparam logic [7:0] BYTE_TAB    = 8'd9;
  localparam logic [7:0] BYTE_LF     = 8'd10;
  localparam logic [7:0] BYTE_CR     = 8'd13;
  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_DEL    = 8'd127;
  localparam logic [7:0] BYTE_CSI    = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SS3    = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'

  // Configuration register map
  localparam int unsigned      CFG_ADDR_W   = 3;
  localparam logic             REG_TIMEOUT  = 1'b0;
  localparam logic [7:0]       TIMEOUT_RST  = 8'd30;

  // One result beat
  typedef struct packed {
    key_t       key;
    logic [7:0] char_value;
    logic       last;
  } res_t;

  // Results decoded for one input beat
  typedef struct packed {
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
  } dec_t;

  // Final letter of a cursor sequence; KEY_CHAR when not a cursor key
  function automatic key_t final_letter(input logic [7:0] b);
    key_t k;
    k = KEY_CHAR;
    case (b)
      8'h41:   k = KEY_UP;     // 'A'
      8'h42:   k = KEY_DOWN;   // 'B'
      8'h43:   k = KEY_RIGHT;  // 'C'
      8'h44:   k = KEY_LEFT;   // 'D'
      8'h48:   k = KEY_HOME;   // 'H'
      8'h46:   k = KEY_END;    // 'F'
      default: k = KEY_CHAR;
    endcase
    return k;
  endfunction

  // Key for a byte seen outside a sequence (ESC handled by the caller)
  function automatic key_t fresh_key(input logic [7:0] b);
    key_t k;
    k = KEY_CHAR;
    case (b)
      BYTE_CR, BYTE_LF:  k = KEY_ENTER;
      BYTE_DEL, BYTE_BS: k = KEY_BACKSPACE;
      BYTE_TAB:          k = KEY_TAB;
      BYTE_CTRL_C:       k = KEY_CTRL_C;
      default:           k = KEY_CHAR;
    endcase
    return k;
  endfunction

  // Build a result beat; the character byte is kept only for plain characters
  function automatic res_t make_res(input key_t k, input logic [7:0] b, input logic lst);
    res_t r;
    r.key        = k;
    r.char_value = (k == KEY_CHAR) ? b : 8'd0;
    r.last       = lst;
    return r;
  endfunction

endpackage

FILE: rtl/core/akd_fsm.sv
// Escape sequence parser: parse state registers and the per-beat decode.
module akd_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,        // input beat accepted this cycle
  input  logic          kind,
  input  logic [7:0]    byte_value,
  input  logic [7:0]    timeout_ticks,
  output akd_pkg::dec_t dec
);
  import akd_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_CSI   = 3'd2,
    MODE_SS3   = 3'd3,
    MODE_TILDE = 3'd4
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] wait_r, wait_nxt;
  key_t       dig_r,  dig_nxt;   // key named by the held digit of ESC [ digit

  logic [7:0] wait_inc;
  key_t       fl_key;
  key_t       fr_key;
  logic       is_digit;
  key_t       digit_key;

  assign wait_inc = (wait_r == 8'hFF) ? wait_r : wait_r + 8'd1;
  assign fl_key   = final_letter(byte_value);
  assign fr_key   = fresh_key(byte_value);

  // Map the digit of ESC [ digit to its key
  always_comb begin
    is_digit  = 1'b1;
    digit_key = KEY_ESCAPE;
    case (byte_value)
      8'h31, 8'h37: digit_key = KEY_HOME;    // '1' '7'
      8'h33:        digit_key = KEY_DELETE;  // '3'
      8'h34, 8'h38: digit_key = KEY_END;     // '4' '8'
      default:      is_digit  = 1'b0;
    endcase
  end

  // Decode one beat against the current parse state
  always_comb begin
    mode_nxt  = mode_r;
    wait_nxt  = wait_r;
    dig_nxt   = dig_r;
    dec.n_res = 2'd0;
    dec.res0  = make_res(KEY_ESCAPE, byte_value, 1'b1);
    dec.res1  = make_res(fr_key, byte_value, 1'b1);
    if (kind == KIND_TICK) begin
      if (mode_r != MODE_IDLE) begin
        wait_nxt = wait_inc;
        if (wait_inc >= timeout_ticks) begin
          mode_nxt  = MODE_IDLE;
          wait_nxt  = 8'd0;
          dig_nxt   = KEY_ESCAPE;
          dec.n_res = 2'd1;
        end
      end
    end else begin
      mode_nxt = MODE_IDLE;
      wait_nxt = 8'd0;
      unique case (mode_r)
        MODE_IDLE: begin
          if (byte_value == BYTE_ESC) begin
            mode_nxt = MODE_ESC;
          end else begin
            dec.n_res = 2'd1;
            dec.res0  = make_res(fr_key, byte_value, 1'b1);
          end
        end
        MODE_ESC: begin
          if (byte_value == BYTE_CSI) begin
            mode_nxt = MODE_CSI;
          end else if (byte_value == BYTE_SS3) begin
            mode_nxt = MODE_SS3;
          end else if (byte_value == BYTE_ESC) begin
            // escape given, a new sequence opens
            mode_nxt  = MODE_ESC;
            dec.n_res = 2'd1;
          end else begin
            // escape, then the byte decoded afresh
            dec.n_res     = 2'd2;
            dec.res0.last = 1'b0;
          end
        end
        MODE_CSI: begin
          if (fl_key != KEY_CHAR) begin
            dec.n_res = 2'd1;
            dec.res0  = make_res(fl_key, byte_value, 1'b1);
          end else if (is_digit) begin
            dig_nxt  = digit_key;
            mode_nxt = MODE_TILDE;
          end else begin
            dec.n_res = 2'd1;
          end
        end
        MODE_SS3: begin
          dec.n_res = 2'd1;
          if (fl_key != KEY_CHAR) begin
            dec.res0 = make_res(fl_key, byte_value, 1'b1);
          end
        end
        MODE_TILDE: begin
          dec.n_res = 2'd1;
          dig_nxt   = KEY_ESCAPE;
          if (byte_value == BYTE_TILDE) begin
            dec.res0 = make_res(dig_r, byte_value, 1'b1);
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  // Hold parse state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      wait_r <= 8'd0;
      dig_r  <= KEY_ESCAPE;
    end else if (take) begin
      mode_r <= mode_nxt;
      wait_r <= wait_nxt;
      dig_r  <= dig_nxt;
    end
  end

endmodule

FILE: rtl/core/ansi_key_sequence_decoder.sv
// Top level of the ANSI key sequence decoder: stream ports, config register and result queue.
//
// Decodes keyboard bytes and timer ticks into key events (enter, backspace, tab, ctrl-c,
// plain characters, and escape / cursor / home / end / delete from ESC [ and ESC O
// sequences). Each input beat is decoded in the cycle it is accepted and yields zero, one
// or two result beats, which go into a three-entry result queue; out_tlast marks the final
// result of an input beat. in_tready is high while at most one result waits, so with a
// consuming sink the block takes one beat per cycle while each beat gives at most one
// result; a beat giving two results can hold off the next input beat. timeout_ticks
// at byte address 0 (reset 30) is the number of ticks after a sequence byte before a lone
// escape is given; zero behaves as one. Write configuration only while the block is idle.
module ansi_key_sequence_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] byte_value
  input  logic                           in_tuser,   // [0] kind
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [3:0] key, [11:4] char_value, zero above
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [akd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import akd_pkg::*;

  localparam int unsigned QDEPTH = 3;

  logic [7:0] timeout_r;
  logic       reg_sel;
  logic       in_take;
  logic       pop;
  dec_t       dec;

  res_t       q_r   [QDEPTH];
  res_t       q_nxt [QDEPTH];
  res_t       q_pop [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt, cnt_pop;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == REG_TIMEOUT);
  assign cfg_prdata = reg_sel ? {24'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      timeout_r <= cfg_pwdata[7:0];
    end
  end

  // Handshakes
  assign in_tready  = (cnt_r <= 2'd1);
  assign in_take    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {4'd0, q_r[0].char_value, q_r[0].key};
  assign out_tlast  = q_r[0].last;

  akd_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (in_take),
    .kind          (in_tuser),
    .byte_value    (in_tdata),
    .timeout_ticks (timeout_r),
    .dec           (dec)
  );

  // Drop the head on a taken beat, then append this beat's results
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_pop[i] = (pop && (i < QDEPTH - 1)) ? q_r[(i + 1) % QDEPTH] : q_r[i];
    end
    cnt_pop = cnt_r - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_pop[i];
      if (in_take && (dec.n_res != 2'd0) && (2'(i) == cnt_pop)) begin
        q_nxt[i] = dec.res0;
      end
      if (in_take && (dec.n_res == 2'd2) && (2'(i) == cnt_pop + 2'd1)) begin
        q_nxt[i] = dec.res1;
      end
    end
    cnt_nxt = cnt_pop + (in_take ? dec.n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Queue occupancy tracks pops and pushes exactly
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 $past(rst_n) |-> cnt_r == $past(cnt_r) - {1'b0, $past(pop)}
      + ($past(in_take) ? $past(dec.n_res) : 2'd0))
    else $error("result queue count mismatch");

  // A non-final result always has its partner already queued
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> cnt_r >= 2'd2)
    else $error("non-final result without its follower");

  // Only plain characters carry a character byte
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] != KEY_CHAR) |-> out_tdata[11:4] == 8'd0)
    else $error("char_value set on a non-character key");

endmodule

FILE: dv/tb_ansi_key_sequence_decoder.sv
// Testbench for the ANSI key sequence decoder: directed table, random key streams, scoreboard.
`timescale 1ns / 100ps

module tb_ansi_key_sequence_decoder;
  import akd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned DIR_ROWS        = 25;
  localparam int unsigned MAX_PRINTED     = 40;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4);

  // Parser position inside an escape sequence
  typedef enum logic [2:0] {
    PM_IDLE,
    PM_ESC,
    PM_CSI,
    PM_SS3,
    PM_TILDE
  } parse_mode_t;

  // One row of the directed table; typed rows carry their expected keys
  typedef struct packed {
    kind_t      kind;
    logic [7:0] bval;
    bit         typed;
    logic [1:0] n_typed;
    key_t       k0;
    logic [7:0] c0;
    key_t       k1;
    logic [7:0] c1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] byte_value
  logic        in_tuser = 1'b0;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;         // [3:0] key, [11:4] char_value
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Key decoder shadow state
  parse_mode_t pm;
  logic [7:0]  pm_digit;
  logic [7:0]  pm_wait;
  logic [7:0]  pm_timeout;
  res_t        key_res [2];
  int unsigned key_n;
  bit          beat_ignored;

  res_t        key_exp_q [$];
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned beats_counted = 0;

  ansi_key_sequence_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- key prediction

  function automatic key_t arrow_key(input logic [7:0] b);
    case (b)
      "A":     return KEY_UP;
      "B":     return KEY_DOWN;
      "C":     return KEY_RIGHT;
      "D":     return KEY_LEFT;
      "H":     return KEY_HOME;
      "F":     return KEY_END;
      default: return KEY_CHAR;
    endcase
  endfunction

  function void emit_key(input key_t k, input logic [7:0] c);
    key_res[key_n].key        = k;
    key_res[key_n].char_value = (k == KEY_CHAR) ? c : 8'd0;
    key_res[key_n].last       = 1'b0;
    key_n = key_n + 1;
  endfunction

  // Decode a byte seen outside any sequence
  function void decode_plain(input logic [7:0] b);
    case (b)
      BYTE_CR, BYTE_LF:  emit_key(KEY_ENTER, b);
      BYTE_BS, BYTE_DEL: emit_key(KEY_BACKSPACE, b);
      BYTE_TAB:          emit_key(KEY_TAB, b);
      BYTE_CTRL_C:       emit_key(KEY_CTRL_C, b);
      BYTE_ESC: begin
        pm      = PM_ESC;
        pm_wait = 8'd0;
      end
      default:           emit_key(KEY_CHAR, b);
    endcase
  endfunction

  // Advance the shadow parser by one input beat and collect the keys it gives
  function void predict_beat(input kind_t kind, input logic [7:0] b);
    parse_mode_t prev;
    key_t        k;
    key_n        = 0;
    beat_ignored = 1'b0;
    prev         = pm;
    if (kind == KIND_TICK) begin
      if (pm == PM_IDLE) begin
        beat_ignored = 1'b1;
      end else begin
        if (pm_wait != 8'hFF) pm_wait = pm_wait + 8'd1;
        if (pm_wait >= pm_timeout) begin
          pm       = PM_IDLE;
          pm_digit = 8'd0;
          pm_wait  = 8'd0;
          emit_key(KEY_ESCAPE, 8'd0);
        end
      end
    end else begin
      pm      = PM_IDLE;
      pm_wait = 8'd0;
      case (prev)
        PM_ESC: begin
          if (b == BYTE_CSI) pm = PM_CSI;
          else if (b == BYTE_SS3) pm = PM_SS3;
          else begin
            emit_key(KEY_ESCAPE, 8'd0);
            decode_plain(b);
          end
        end
        PM_CSI: begin
          k = arrow_key(b);
          if (k != KEY_CHAR) emit_key(k, 8'd0);
          else if (b == "1" || b == "3" || b == "4" || b == "7" || b == "8") begin
            pm_digit = b;
            pm       = PM_TILDE;
          end else emit_key(KEY_ESCAPE, 8'd0);
        end
        PM_SS3: begin
          k = arrow_key(b);
          emit_key((k != KEY_CHAR) ? k : KEY_ESCAPE, 8'd0);
        end
        PM_TILDE: begin
          k = KEY_ESCAPE;
          if (b == BYTE_TILDE) begin
            case (pm_digit)
              "1", "7": k = KEY_HOME;
              "3":      k = KEY_DELETE;
              "4", "8": k = KEY_END;
              default:  k = KEY_ESCAPE;
            endcase
          end
          pm_digit = 8'd0;
          emit_key(k, 8'd0);
        end
        default: decode_plain(b);
      endcase
    end
    if (key_n > 0) key_res[key_n - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- result check

  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (key_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat key %0d char %02h last %0b",
                                  out_tdata[3:0], out_tdata[11:4], out_tlast));
      end else begin
        want = key_exp_q.pop_front();
        if (out_tdata[3:0] != want.key)
          report_mismatch($sformatf("key %0d, want %0d", out_tdata[3:0], want.key));
        if (out_tdata[11:4] != want.char_value)
          report_mismatch($sformatf("char %02h, want %02h", out_tdata[11:4], want.char_value));
        if (out_tlast != want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
      end
    end
  end

  // Stall the result side per phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // ---------------------------------------------------------------- drivers

  // Hold one input beat until accepted, then predict it
  task send_beat(input kind_t kind, input logic [7:0] b, input bit use_pred);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    predict_beat(kind, b);
    if (!beat_ignored) beats_counted++;
    if (use_pred) begin
      for (int i = 0; i < key_n; i++) key_exp_q.push_back(key_res[i]);
    end
  endtask

  task send_key(input logic [7:0] b);
    send_beat(KIND_BYTE, b, 1'b1);
  endtask

  task send_ticks(input int unsigned n);
    repeat (n) send_beat(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and wait out every pending key
  task wait_drained;
    in_tvalid <= 1'b0;
    while (key_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_TIMEOUT) pm_timeout = value;
    // Leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task cfg_check(input logic [7:0] want);
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_TIMEOUT;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got[7:0] != want)
      report_mismatch($sformatf("timeout_ticks reads %0d, want %0d", got[7:0], want));
  endtask

  // ---------------------------------------------------------------- random stimulus

  function automatic logic [7:0] pick_plain();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       return BYTE_CR;
      1:       return BYTE_LF;
      2:       return BYTE_BS;
      3:       return BYTE_DEL;
      4:       return BYTE_TAB;
      5:       return BYTE_CTRL_C;
      6:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_final();
    case ($urandom_range(0, 5))
      0:       return "A";
      1:       return "B";
      2:       return "C";
      3:       return "D";
      4:       return "H";
      default: return "F";
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    case ($urandom_range(0, 4))
      0:       return "1";
      1:       return "3";
      2:       return "4";
      3:       return "7";
      default: return "8";
    endcase
  endfunction

  // Insert a few ticks that stay short of the timeout
  task short_pause(input int unsigned eff);
    if (eff > 1 && $urandom_range(0, 3) == 0)
      send_ticks($urandom_range(1, (eff - 1 < 3) ? eff - 1 : 3));
  endtask

  // Send one unit: plain byte, well-formed sequence, broken sequence, timeout or stray ticks
  task random_unit;
    int unsigned r;
    int unsigned eff;
    int unsigned n;
    eff = (pm_timeout == 8'd0) ? 1 : pm_timeout;
    r   = $urandom_range(0, 99);
    if (r < 30) begin
      send_key(pick_plain());
    end else if (r < 65) begin
      send_key(BYTE_ESC);
      short_pause(eff);
      if ($urandom_range(0, 1)) begin
        send_key(BYTE_SS3);
        short_pause(eff);
        send_key(pick_final());
      end else begin
        send_key(BYTE_CSI);
        short_pause(eff);
        if ($urandom_range(0, 9) < 4) begin
          send_key(pick_digit());
          short_pause(eff);
          send_key(BYTE_TILDE);
        end else begin
          send_key(pick_final());
        end
      end
    end else if (r < 80) begin
      send_key(BYTE_ESC);
      case ($urandom_range(0, 3))
        0: send_key(8'($urandom_range(0, 255)));
        1: begin
          send_key(BYTE_CSI);
          send_key(8'($urandom_range(0, 255)));
        end
        2: begin
          send_key(BYTE_CSI);
          send_key(pick_digit());
          send_key(8'($urandom_range(0, 255)));
        end
        default: begin
          send_key(BYTE_SS3);
          send_key(8'($urandom_range(0, 255)));
        end
      endcase
    end else if (r < 92) begin
      // Let an open sequence run up to or past its timeout; with a long timeout, usually a short pause
      send_key(BYTE_ESC);
      case ($urandom_range(0, 3))
        1: send_key(BYTE_CSI);
        2: send_key(BYTE_SS3);
        3: begin
          send_key(BYTE_CSI);
          send_key(pick_digit());
        end
        default: ;
      endcase
      if (eff <= 40 || $urandom_range(0, 15) == 0) n = eff - 1 + $urandom_range(0, 2);
      else n = $urandom_range(1, 4);
      send_ticks(n);
    end else begin
      send_ticks($urandom_range(1, 3));
    end
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    dir_row_t    rows [DIR_ROWS];
    res_t        typed_res;
    logic [7:0]  tmo;
    bit          paused;

    pm         = PM_IDLE;
    pm_digit   = 8'd0;
    pm_wait    = 8'd0;
    pm_timeout = TIMEOUT_RST;

    rows[0]  = '{KIND_BYTE, "a",         1'b1, 2'd1, KEY_CHAR,      "a",   KEY_CHAR, 8'h00};
    rows[1]  = '{KIND_BYTE, 8'h00,       1'b1, 2'd1, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[2]  = '{KIND_BYTE, 8'hFF,       1'b1, 2'd1, KEY_CHAR,      8'hFF, KEY_CHAR, 8'h00};
    rows[3]  = '{KIND_BYTE, BYTE_CR,     1'b1, 2'd1, KEY_ENTER,     8'h00, KEY_CHAR, 8'h00};
    rows[4]  = '{KIND_BYTE, BYTE_BS,     1'b1, 2'd1, KEY_BACKSPACE, 8'h00, KEY_CHAR, 8'h00};
    rows[5]  = '{KIND_BYTE, BYTE_DEL,    1'b1, 2'd1, KEY_BACKSPACE, 8'h00, KEY_CHAR, 8'h00};
    rows[6]  = '{KIND_BYTE, BYTE_TAB,    1'b1, 2'd1, KEY_TAB,       8'h00, KEY_CHAR, 8'h00};
    rows[7]  = '{KIND_BYTE, BYTE_CTRL_C, 1'b1, 2'd1, KEY_CTRL_C,    8'h00, KEY_CHAR, 8'h00};
    rows[8]  = '{KIND_BYTE, BYTE_ESC,    1'b1, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[9]  = '{KIND_BYTE, BYTE_CSI,    1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[10] = '{KIND_BYTE, "A",         1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[11] = '{KIND_BYTE, BYTE_ESC,    1'b1, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[12] = '{KIND_BYTE, BYTE_SS3,    1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[13] = '{KIND_BYTE, "F",         1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[14] = '{KIND_BYTE, BYTE_ESC,    1'b1, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[15] = '{KIND_BYTE, BYTE_CSI,    1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[16] = '{KIND_BYTE, "3",         1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[17] = '{KIND_BYTE, BYTE_TILDE,  1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    // ESC then an unrelated byte: escape, then the byte on its own
    rows[18] = '{KIND_BYTE, BYTE_ESC,    1'b1, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[19] = '{KIND_BYTE, "x",         1'b1, 2'd2, KEY_ESCAPE,    8'h00, KEY_CHAR, "x"};
    // ESC twice: one escape and the sequence stays open
    rows[20] = '{KIND_BYTE, BYTE_ESC,    1'b1, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[21] = '{KIND_BYTE, BYTE_ESC,    1'b1, 2'd1, KEY_ESCAPE,    8'h00, KEY_CHAR, 8'h00};
    rows[22] = '{KIND_TICK, 8'hA5,       1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[23] = '{KIND_BYTE, BYTE_CSI,    1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};
    rows[24] = '{KIND_BYTE, "Z",         1'b0, 2'd0, KEY_CHAR,      8'h00, KEY_CHAR, 8'h00};

    // Hold reset, then release at a clock edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check(TIMEOUT_RST);

    // Walk the directed table without idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(rows[i].kind, rows[i].bval, !rows[i].typed);
      if (rows[i].typed && rows[i].n_typed != 2'd0) begin
        typed_res.key        = rows[i].k0;
        typed_res.char_value = rows[i].c0;
        typed_res.last       = (rows[i].n_typed == 2'd1);
        key_exp_q.push_back(typed_res);
        if (rows[i].n_typed == 2'd2) begin
          typed_res.key        = rows[i].k1;
          typed_res.char_value = rows[i].c1;
          typed_res.last       = 1'b1;
          key_exp_q.push_back(typed_res);
        end
      end
    end
    wait_drained();

    // Random phases across idling patterns and timeout settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      case (p)
        0:       tmo = 8'd30;
        1:       tmo = 8'd1;
        2:       tmo = 8'd255;
        3:       tmo = 8'd0;
        4:       tmo = 8'd3;
        5:       tmo = 8'd30;
        6:       tmo = 8'd2;
        default: tmo = 8'd12;
      endcase
      if (p == 4) cfg_write(ADDR_UNMAPPED, 8'h07);
      cfg_write(ADDR_TIMEOUT, tmo);
      cfg_check(tmo);

      beats_counted = 0;
      paused        = 1'b0;
      while (beats_counted < ITEMS_PER_PHASE) begin
        random_unit();
        // Pause the sender once per phase until the result side is empty
        if (!paused && beats_counted >= ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      // Close any open sequence before the next register write
      if (pm != PM_IDLE) send_key("z");
      wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
